// ===== sv/mpe_pkg.sv =====
// Shared constants, widths, codes and types of the midpoint ellipse outline block.
// No dependencies; the other design files refer to this package by scoped names, the bench imports it.
package mpe_pkg;

  localparam int RADIUS_BITS = 12;
  localparam int COORD_BITS  = 16;
  localparam int CANVAS_BITS = 16;
  localparam int COLOR_BITS  = 32;

  localparam int PT_W    = COORD_BITS + 1;
  localparam int XW      = RADIUS_BITS + 1;
  localparam int STEP_W  = RADIUS_BITS + 2;
  localparam int SQ_W    = 2 * RADIUS_BITS;
  localparam int MUL_W   = 2 * RADIUS_BITS + 2;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SLOPE_W = 3 * RADIUS_BITS + 4;
  localparam int DEC_W   = PROD_W;
  localparam int SUM_W   = COORD_BITS + RADIUS_BITS + 3;

  localparam int CFG_IDX_W = 1;
  localparam logic [CANVAS_BITS-1:0] CANVAS_RESET = CANVAS_BITS'(1024);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CANVAS_W = 1'b0,
    CFG_CANVAS_H = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_RXRY,
    ST_INIT,
    ST_EMIT,
    ST_UPD,
    ST_UPD2,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6
  } state_t;

  typedef struct packed {
    logic load;
    logic neg_x;
    logic neg_y;
    logic last;
  } pt_req_t;

endpackage

// ===== sv/mpe_if.sv =====
// Valid/ready channel interfaces for command beats in and outline point beats out.
// Depends on mpe_pkg for field widths.
interface mpe_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic signed [mpe_pkg::COORD_BITS-1:0]  center_x;
  logic signed [mpe_pkg::COORD_BITS-1:0]  center_y;
  logic        [mpe_pkg::RADIUS_BITS-1:0] radius_x;
  logic        [mpe_pkg::RADIUS_BITS-1:0] radius_y;
  logic        [mpe_pkg::COLOR_BITS-1:0]  color;

  modport source (output valid, command, center_x, center_y, radius_x, radius_y, color,
                  input ready);
  modport sink (input valid, command, center_x, center_y, radius_x, radius_y, color,
                output ready);
endinterface

interface mpe_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mpe_pkg::PT_W-1:0]       point_x;
  logic signed [mpe_pkg::PT_W-1:0]       point_y;
  logic        [mpe_pkg::COLOR_BITS-1:0] point_color;
  logic                               inside_canvas;
  logic                               last_point;

  modport source (output valid, point_x, point_y, point_color, inside_canvas, last_point,
                  input ready);
  modport sink (input valid, point_x, point_y, point_color, inside_canvas, last_point,
                output ready);
endinterface

// ===== sv/mpe_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on mpe_pkg for operand widths.
module mpe_mul (
  input  logic                        clk,
  input  logic [mpe_pkg::MUL_W-1:0]   a,
  input  logic [mpe_pkg::MUL_W-1:0]   b,
  output logic [mpe_pkg::PROD_W-1:0]  p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ===== sv/mpe_point.sv =====
// Point output stage: mirrors one step point, flags canvas bounds and holds the beat.
// Depends on mpe_pkg and the mpe_out_if interface.
module mpe_point (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mpe_pkg::pt_req_t                     req,
  input  logic signed [mpe_pkg::COORD_BITS-1:0]  cx,
  input  logic signed [mpe_pkg::COORD_BITS-1:0]  cy,
  input  logic        [mpe_pkg::XW-1:0]          step_x,
  input  logic signed [mpe_pkg::STEP_W-1:0]      step_y,
  input  logic        [mpe_pkg::COLOR_BITS-1:0]  color,
  input  logic        [mpe_pkg::CANVAS_BITS-1:0] width_lim,
  input  logic        [mpe_pkg::CANVAS_BITS-1:0] height_lim,
  output logic                                 rdy,
  mpe_out_if.source                            out_ch
);

  localparam int SUM_W = mpe_pkg::SUM_W;

  logic signed [SUM_W-1:0] cxe, cye, xe, ye, sx, sy;
  logic                    in_bounds;

  logic                               valid_r;
  logic signed [mpe_pkg::PT_W-1:0]       px_r, py_r;
  logic        [mpe_pkg::COLOR_BITS-1:0] color_r;
  logic                               in_bounds_r, last_r;

  assign cxe = SUM_W'(cx);
  assign cye = SUM_W'(cy);
  assign xe  = $signed(SUM_W'(step_x));
  assign ye  = SUM_W'(step_y);
  assign sx  = req.neg_x ? cxe - xe : cxe + xe;
  assign sy  = req.neg_y ? cye - ye : cye + ye;

  assign in_bounds = !sx[SUM_W-1] && !sy[SUM_W-1] &&
                     (sx[SUM_W-2:0] < (SUM_W-1)'(width_lim)) &&
                     (sy[SUM_W-2:0] < (SUM_W-1)'(height_lim));

  assign rdy = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rdy) begin
      valid_r <= req.load;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && req.load) begin
      px_r        <= sx[mpe_pkg::PT_W-1:0];
      py_r        <= sy[mpe_pkg::PT_W-1:0];
      color_r     <= color;
      in_bounds_r <= in_bounds;
      last_r      <= req.last;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.point_x       = px_r;
  assign out_ch.point_y       = py_r;
  assign out_ch.point_color   = color_r;
  assign out_ch.inside_canvas = in_bounds_r;
  assign out_ch.last_point    = last_r;

endmodule

// ===== sv/midpoint_ellipse_outline_top.sv =====
// Top level of the midpoint ellipse outline generator: sequencer, decision datapath,
// canvas registers. Depends on mpe_pkg, mpe_if, mpe_mul and mpe_point.
//
//   channel  | dir | handshake       | payload
//   in_ch    | in  | valid/ready     | command, center_x/y, radius_x/y, color
//   out_ch   | out | valid/ready     | point_x/y, point_color, inside_canvas, last_point
//   cfg_*    | in  | cfg_we, no wait | cfg_idx, cfg_data (canvas width, height)
//
// A start beat makes three passes through the shared multiplier, then a sum.
// A next beat sends 4 point beats through the single output register, then runs the
// update states UPD and UPD2; the step that enters region 2 adds 5 multiplies and a
// final sum. A next beat with no active outline gives nothing.
// Reset is synchronous: idle, canvas registers at 1024. A stalled out_ch holds the
// sequencer in its emit state and in_ch.ready stays low until the step is done.
module midpoint_ellipse_outline_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  mpe_in_if.sink                                in_ch,
  mpe_out_if.source                             out_ch,
  input  logic                                  cfg_we,
  input  logic [mpe_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [mpe_pkg::CANVAS_BITS-1:0]       cfg_data
);

  localparam int R       = mpe_pkg::RADIUS_BITS;
  localparam int XW      = mpe_pkg::XW;
  localparam int STEP_W  = mpe_pkg::STEP_W;
  localparam int SQ_W    = mpe_pkg::SQ_W;
  localparam int MUL_W   = mpe_pkg::MUL_W;
  localparam int PROD_W  = mpe_pkg::PROD_W;
  localparam int SLOPE_W = mpe_pkg::SLOPE_W;
  localparam int DEC_W   = mpe_pkg::DEC_W;

  mpe_pkg::state_t state_r, state_nxt;

  logic        active_r, region_two_r;
  logic [1:0]  idx_r;
  logic        br_r;

  logic        [R-1:0]                   rx_r, ry_r;
  logic signed [mpe_pkg::COORD_BITS-1:0]  cx_r, cy_r;
  logic        [mpe_pkg::COLOR_BITS-1:0]  color_r;
  logic        [SQ_W-1:0]                rxsq_r, rysq_r;
  logic        [XW-1:0]                  step_x_r;
  logic signed [STEP_W-1:0]              step_y_r;
  logic signed [SLOPE_W-1:0]             slope_x_r, slope_y_r;
  logic signed [DEC_W-1:0]               dec_r;
  logic        [mpe_pkg::CANVAS_BITS-1:0] width_lim_r, height_lim_r;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  mpe_pkg::pt_req_t pt_req;
  logic             pt_rdy;
  logic             in_ready;

  logic                      start_beat, next_beat;
  logic signed [STEP_W-1:0]  ym1, ym1_abs;
  logic signed [SLOPE_W-1:0] two_rxsq, two_rysq;
  logic signed [DEC_W-1:0]   init_w, init_dec, reg2_w, reg2_dec;
  logic signed [DEC_W-1:0]   dec_r1, dec_r2;
  logic                      dec_neg, dec_pos;

  assign start_beat = in_ch.valid && in_ready && (in_ch.command == mpe_pkg::CMD_START);
  assign next_beat  = in_ch.valid && in_ready && (in_ch.command == mpe_pkg::CMD_NEXT);

  assign ym1     = step_y_r - STEP_W'(1);
  assign ym1_abs = ym1[STEP_W-1] ? -ym1 : ym1;

  assign two_rxsq = $signed(SLOPE_W'({rxsq_r, 1'b0}));
  assign two_rysq = $signed(SLOPE_W'({rysq_r, 1'b0}));

  assign dec_neg = dec_r[DEC_W-1];
  assign dec_pos = !dec_r[DEC_W-1] && (dec_r != '0);

  assign init_w   = $signed(DEC_W'(rysq_r)) - $signed(prod)
                  + $signed(DEC_W'(rxsq_r[SQ_W-1:2]));
  assign init_dec = init_w + DEC_W'(init_w[DEC_W-1] && (rxsq_r[1:0] != 2'b00));

  assign reg2_w   = dec_r - $signed(prod) + $signed(DEC_W'(rysq_r[SQ_W-1:2]));
  assign reg2_dec = reg2_w + DEC_W'(reg2_w[DEC_W-1] && (rysq_r[1:0] != 2'b00));

  assign dec_r1 = dec_r + $signed(DEC_W'(rysq_r)) + DEC_W'(slope_x_r)
                - (br_r ? DEC_W'(slope_y_r) : '0);
  assign dec_r2 = dec_r + $signed(DEC_W'(rxsq_r)) - DEC_W'(slope_y_r)
                + (br_r ? DEC_W'(slope_x_r) : '0);

  mpe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  mpe_point u_point (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (pt_req),
    .cx         (cx_r),
    .cy         (cy_r),
    .step_x     (step_x_r),
    .step_y     (step_y_r),
    .color      (color_r),
    .width_lim  (width_lim_r),
    .height_lim (height_lim_r),
    .rdy        (pt_rdy),
    .out_ch     (out_ch)
  );

  assign in_ch.ready = in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpe_pkg::ST_IDLE: begin
        if (start_beat) begin
          state_nxt = mpe_pkg::ST_SQX;
        end else if (next_beat && active_r) begin
          state_nxt = mpe_pkg::ST_EMIT;
        end
      end
      mpe_pkg::ST_SQX:  state_nxt = mpe_pkg::ST_SQY;
      mpe_pkg::ST_SQY:  state_nxt = mpe_pkg::ST_RXRY;
      mpe_pkg::ST_RXRY: state_nxt = mpe_pkg::ST_INIT;
      mpe_pkg::ST_INIT: state_nxt = mpe_pkg::ST_IDLE;
      mpe_pkg::ST_EMIT: begin
        if (pt_rdy && idx_r == 2'd3) begin
          state_nxt = mpe_pkg::ST_UPD;
        end
      end
      mpe_pkg::ST_UPD:  state_nxt = mpe_pkg::ST_UPD2;
      mpe_pkg::ST_UPD2: begin
        if (!region_two_r && slope_x_r >= slope_y_r) begin
          state_nxt = mpe_pkg::ST_M1;
        end else begin
          state_nxt = mpe_pkg::ST_IDLE;
        end
      end
      mpe_pkg::ST_M1:   state_nxt = mpe_pkg::ST_M2;
      mpe_pkg::ST_M2:   state_nxt = mpe_pkg::ST_M3;
      mpe_pkg::ST_M3:   state_nxt = mpe_pkg::ST_M4;
      mpe_pkg::ST_M4:   state_nxt = mpe_pkg::ST_M5;
      mpe_pkg::ST_M5:   state_nxt = mpe_pkg::ST_M6;
      mpe_pkg::ST_M6:   state_nxt = mpe_pkg::ST_IDLE;
      default:          state_nxt = mpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    pt_req.load  = 1'b0;
    pt_req.neg_x = idx_r[0];
    pt_req.neg_y = idx_r[1];
    pt_req.last  = (idx_r == 2'd3) && region_two_r && (step_y_r == '0);
    unique case (state_r)
      mpe_pkg::ST_IDLE: in_ready = 1'b1;
      mpe_pkg::ST_SQX: begin
        mul_a = MUL_W'(rx_r);
        mul_b = MUL_W'(rx_r);
      end
      mpe_pkg::ST_SQY: begin
        mul_a = MUL_W'(ry_r);
        mul_b = MUL_W'(ry_r);
      end
      mpe_pkg::ST_RXRY: begin
        mul_a = MUL_W'(rxsq_r);
        mul_b = MUL_W'(ry_r);
      end
      mpe_pkg::ST_EMIT: pt_req.load = 1'b1;
      mpe_pkg::ST_M1: begin
        mul_a = MUL_W'(step_x_r);
        mul_b = MUL_W'(step_x_r) + MUL_W'(1);
      end
      mpe_pkg::ST_M2: begin
        mul_a = MUL_W'(rysq_r);
        mul_b = prod[MUL_W-1:0];
      end
      mpe_pkg::ST_M3: begin
        mul_a = MUL_W'(unsigned'(ym1_abs));
        mul_b = MUL_W'(unsigned'(ym1_abs));
      end
      mpe_pkg::ST_M4: begin
        mul_a = MUL_W'(rxsq_r);
        mul_b = prod[MUL_W-1:0];
      end
      mpe_pkg::ST_M5: begin
        mul_a = MUL_W'(rxsq_r);
        mul_b = MUL_W'(rysq_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mpe_pkg::ST_IDLE;
      active_r     <= 1'b0;
      region_two_r <= 1'b0;
      idx_r        <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (start_beat) begin
        region_two_r <= 1'b0;
      end
      if (next_beat) begin
        idx_r <= 2'd0;
      end
      if (state_r == mpe_pkg::ST_INIT) begin
        active_r <= (rx_r != '0) && (ry_r != '0);
      end
      if (state_r == mpe_pkg::ST_EMIT && pt_rdy) begin
        idx_r <= idx_r + 2'd1;
      end
      if (state_r == mpe_pkg::ST_UPD2 && region_two_r && step_y_r[STEP_W-1]) begin
        active_r <= 1'b0;
      end
      if (state_r == mpe_pkg::ST_M6) begin
        region_two_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      mpe_pkg::ST_IDLE: begin
        if (start_beat) begin
          rx_r      <= in_ch.radius_x;
          ry_r      <= in_ch.radius_y;
          cx_r      <= in_ch.center_x;
          cy_r      <= in_ch.center_y;
          color_r   <= in_ch.color;
          step_x_r  <= '0;
          step_y_r  <= $signed(STEP_W'(in_ch.radius_y));
          slope_x_r <= '0;
        end
      end
      mpe_pkg::ST_SQY:  rxsq_r <= prod[SQ_W-1:0];
      mpe_pkg::ST_RXRY: rysq_r <= prod[SQ_W-1:0];
      mpe_pkg::ST_INIT: begin
        slope_y_r <= $signed({prod[SLOPE_W-2:0], 1'b0});
        dec_r     <= init_dec;
      end
      mpe_pkg::ST_UPD: begin
        if (!region_two_r) begin
          step_x_r  <= step_x_r + XW'(1);
          slope_x_r <= slope_x_r + two_rysq;
          br_r      <= !dec_neg;
          if (!dec_neg) begin
            step_y_r  <= step_y_r - STEP_W'(1);
            slope_y_r <= slope_y_r - two_rxsq;
          end
        end else begin
          step_y_r  <= step_y_r - STEP_W'(1);
          slope_y_r <= slope_y_r - two_rxsq;
          br_r      <= !dec_pos;
          if (!dec_pos) begin
            step_x_r  <= step_x_r + XW'(1);
            slope_x_r <= slope_x_r + two_rysq;
          end
        end
      end
      mpe_pkg::ST_UPD2: dec_r <= region_two_r ? dec_r2 : dec_r1;
      mpe_pkg::ST_M3:   dec_r <= $signed(prod);
      mpe_pkg::ST_M5:   dec_r <= dec_r + $signed(prod);
      mpe_pkg::ST_M6:   dec_r <= reg2_dec;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_lim_r  <= mpe_pkg::CANVAS_RESET;
      height_lim_r <= mpe_pkg::CANVAS_RESET;
    end else if (cfg_we) begin
      unique case (mpe_pkg::cfg_reg_t'(cfg_idx))
        mpe_pkg::CFG_CANVAS_W: width_lim_r  <= cfg_data;
        mpe_pkg::CFG_CANVAS_H: height_lim_r <= cfg_data;
        default:               width_lim_r  <= width_lim_r;
      endcase
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for midpoint_ellipse_outline_top: directed and random command beats,
// an in-bench outline predictor and a point-by-point scoreboard on the result channel.
// Depends on mpe_pkg and the mpe_in_if / mpe_out_if interfaces.
module tb_top;
  import mpe_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 32;
  localparam int RANDOM_BEATS  = 316;
  localparam int LONG_HOLD     = 400;
  localparam int PRINT_CAP     = 40;

  typedef enum int {
    RECV_FREE,
    RECV_LIGHT_STALL,
    RECV_HEAVY_STALL,
    RECV_PERIODIC
  } recv_mode_t;

  typedef struct {
    logic                   cmd;
    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [RADIUS_BITS-1:0] rx;
    logic [RADIUS_BITS-1:0] ry;
    logic [COLOR_BITS-1:0]  col;
  } cmd_beat_t;

  typedef struct {
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic [COLOR_BITS-1:0]  col;
    logic                   in_bounds;
    logic                   last;
  } outline_point_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CANVAS_BITS-1:0] cfg_data;

  mpe_in_if  in_if ();
  mpe_out_if out_if ();

  midpoint_ellipse_outline_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // predictor state
  longint lim_width;
  longint lim_height;
  bit     ell_active;
  bit     ell_region_two;
  longint ctr_x;
  longint ctr_y;
  longint pos_x;
  longint pos_y;
  longint slope_x;
  longint slope_y;
  longint dec_var;
  longint rx_sq;
  longint ry_sq;
  logic [COLOR_BITS-1:0] ell_color;

  outline_point_t due_points[$];
  outline_point_t want;

  int fault_count = 0;
  int useful_beats;
  int burst_left;
  int hold_ask;
  int hold_seen = 0;
  int hold_len = 0;
  int mode_left = 0;
  int ready_tick = 0;
  int cycle_count = 0;
  recv_mode_t recv_mode = RECV_FREE;

  always #1 clk = ~clk;

  function automatic outline_point_t make_point(longint px, longint py, bit last);
    outline_point_t p;
    p.px        = px[PT_W-1:0];
    p.py        = py[PT_W-1:0];
    p.col       = ell_color;
    p.in_bounds = (px >= 0) && (py >= 0) && (px < lim_width) && (py < lim_height);
    p.last      = last;
    return p;
  endfunction

  function automatic longint trunc_quarter(longint whole, longint frac);
    if (frac != 0 && whole < 0) return whole + 1;
    return whole;
  endfunction

  function automatic void step_outline(input cmd_beat_t b);
    longint rx;
    longint ry;
    longint ux;
    longint ym;
    longint w;
    bit     last;
    if (b.cmd == CMD_START) begin
      rx             = longint'(b.rx);
      ry             = longint'(b.ry);
      ctr_x          = longint'($signed(b.cx));
      ctr_y          = longint'($signed(b.cy));
      ell_color      = b.col;
      rx_sq          = rx * rx;
      ry_sq          = ry * ry;
      pos_x          = 0;
      pos_y          = ry;
      slope_x        = 0;
      slope_y        = 2 * rx_sq * ry;
      ell_region_two = 1'b0;
      ell_active     = (rx != 0) && (ry != 0);
      w              = ry_sq - rx_sq * ry + (rx_sq >>> 2);
      dec_var        = trunc_quarter(w, rx_sq & 3);
      return;
    end
    if (!ell_active) return;
    last = ell_region_two && (pos_y == 0);
    due_points.push_back(make_point(ctr_x + pos_x, ctr_y + pos_y, 1'b0));
    due_points.push_back(make_point(ctr_x - pos_x, ctr_y + pos_y, 1'b0));
    due_points.push_back(make_point(ctr_x + pos_x, ctr_y - pos_y, 1'b0));
    due_points.push_back(make_point(ctr_x - pos_x, ctr_y - pos_y, last));
    if (!ell_region_two) begin
      pos_x++;
      slope_x += 2 * ry_sq;
      if (dec_var < 0) begin
        dec_var += ry_sq + slope_x;
      end else begin
        pos_y--;
        slope_y -= 2 * rx_sq;
        dec_var += ry_sq + slope_x - slope_y;
      end
      if (slope_x >= slope_y) begin
        ux = pos_x;
        ym = pos_y - 1;
        w  = ry_sq * ux * (ux + 1) + rx_sq * ym * ym - rx_sq * ry_sq + (ry_sq >>> 2);
        dec_var        = trunc_quarter(w, ry_sq & 3);
        ell_region_two = 1'b1;
      end
    end else begin
      pos_y--;
      slope_y -= 2 * rx_sq;
      if (dec_var > 0) begin
        dec_var += rx_sq - slope_y;
      end else begin
        pos_x++;
        slope_x += 2 * ry_sq;
        dec_var += rx_sq - slope_y + slope_x;
      end
      if (pos_y < 0) ell_active = 1'b0;
    end
  endfunction

  function automatic cmd_beat_t start_beat(int cx, int cy, int rx, int ry, logic [31:0] col);
    cmd_beat_t b;
    b.cmd = CMD_START;
    b.cx  = cx[COORD_BITS-1:0];
    b.cy  = cy[COORD_BITS-1:0];
    b.rx  = rx[RADIUS_BITS-1:0];
    b.ry  = ry[RADIUS_BITS-1:0];
    b.col = col;
    return b;
  endfunction

  // payload of a next beat is ignored: fill it with noise
  function automatic cmd_beat_t next_beat();
    cmd_beat_t b;
    b     = start_beat($urandom, $urandom, $urandom, $urandom, $urandom);
    b.cmd = CMD_NEXT;
    return b;
  endfunction

  function automatic logic [CANVAS_BITS-1:0] pick_canvas();
    case ($urandom_range(0, 4))
      0:       return CANVAS_BITS'($urandom_range(1, 64));
      1:       return CANVAS_BITS'($urandom_range(0, 65535));
      2:       return CANVAS_BITS'(32768);
      3:       return CANVAS_BITS'($urandom_range(1, 8));
      default: return CANVAS_RESET;
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    fault_count++;
    if (fault_count <= PRINT_CAP) $display("mismatch @%0d: %s", cycle_count, what);
  endtask

  task automatic send_beat(input cmd_beat_t b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_if.valid    <= 1'b1;
    in_if.command  <= b.cmd;
    in_if.center_x <= b.cx;
    in_if.center_y <= b.cy;
    in_if.radius_x <= b.rx;
    in_if.radius_y <= b.ry;
    in_if.color    <= b.col;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (!(b.cmd == CMD_NEXT && !ell_active)) useful_beats++;
    step_outline(b);
  endtask

  task automatic trace_outline(int max_steps);
    int n;
    n = 0;
    while (ell_active && n < max_steps) begin
      send_beat(next_beat());
      n++;
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (due_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_canvas(cfg_reg_t which, logic [CANVAS_BITS-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= which;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (which == CFG_CANVAS_W) lim_width  = longint'(val);
    else                       lim_height = longint'(val);
  endtask

  task automatic test_idle_and_zero_radius();
    send_beat(next_beat());
    send_beat(start_beat(10, 10, 0, 5, 32'h1234_5678));
    send_beat(next_beat());
    send_beat(start_beat(-3, 7, 2, 0, 32'h8765_4321));
    send_beat(next_beat());
  endtask

  task automatic test_extremes_and_restart();
    send_beat(start_beat(32767, -32768, 4095, 4095, 32'hFFFF_FFFF));
    trace_outline(2);
    send_beat(start_beat(-32768, 32767, 1, 1, 32'h0000_0000));
    trace_outline(1000);
    send_beat(next_beat());
    send_beat(start_beat(5, 5, 3, 2, 32'hA5A5_5A5A));
    trace_outline(1000);
    send_beat(start_beat(0, 0, 1, 4095, 32'h5A5A_A5A5));
    trace_outline(1);
    send_beat(start_beat(0, 0, 0, 0, 32'h0F0F_F0F0));
    send_beat(next_beat());
    settle();
  endtask

  task automatic test_canvas_bounds();
    write_canvas(CFG_CANVAS_W, '0);
    send_beat(start_beat(5, 5, 1, 1, 32'hC0DE_0001));
    trace_outline(1000);
    settle();
    write_canvas(CFG_CANVAS_W, 16'hFFFF);
    write_canvas(CFG_CANVAS_H, '0);
    send_beat(start_beat(5, 5, 1, 1, 32'hC0DE_0002));
    trace_outline(1000);
    settle();
    write_canvas(CFG_CANVAS_H, 16'hFFFF);
    send_beat(start_beat(1, 1, 2, 1, 32'hC0DE_0003));
    trace_outline(1000);
    settle();
    write_canvas(CFG_CANVAS_W, 16'd1);
    write_canvas(CFG_CANVAS_H, 16'd32768);
    send_beat(start_beat(0, 2, 1, 2, 32'hC0DE_0004));
    trace_outline(1000);
    settle();
    write_canvas(CFG_CANVAS_W, CANVAS_RESET);
    write_canvas(CFG_CANVAS_H, CANVAS_RESET);
  endtask

  task automatic test_output_stall();
    hold_ask++;
    send_beat(start_beat(6, 4, 12, 7, $urandom));
    trace_outline(1000);
    settle();
  endtask

  task automatic test_random_ellipses();
    int target;
    int pick;
    int rx;
    int ry;
    int cx;
    int cy;
    int cut;
    target = useful_beats + RANDOM_BEATS;
    while (useful_beats < target) begin
      if ($urandom_range(0, 39) == 0) begin
        settle();
        write_canvas(CFG_CANVAS_W, pick_canvas());
        write_canvas(CFG_CANVAS_H, pick_canvas());
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_beat(next_beat());
        continue;
      end
      if (pick < 10) begin
        rx = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4095);
        ry = (rx != 0) ? 0 : $urandom_range(0, 4095);
      end else if (pick < 86) begin
        rx = $urandom_range(1, 12);
        ry = $urandom_range(1, 12);
      end else if (pick < 96) begin
        rx = $urandom_range(1, 40);
        ry = $urandom_range(1, 40);
      end else begin
        rx = $urandom_range(1, 4095);
        ry = $urandom_range(1, 4095);
      end
      if ($urandom_range(0, 1)) begin
        cx = $urandom_range(0, 40) - 8;
        cy = $urandom_range(0, 40) - 8;
      end else begin
        cx = $urandom;
        cy = $urandom;
      end
      send_beat(start_beat(cx, cy, rx, ry, $urandom));
      if (pick >= 96)                      cut = $urandom_range(0, 6);
      else if ($urandom_range(0, 9) == 0)  cut = $urandom_range(0, rx + ry);
      else                                 cut = 1 << 30;
      trace_outline(cut);
    end
  endtask

  // result side: stall pattern, long hold on request
  always @(negedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_len  = LONG_HOLD;
    end
    if (hold_len > 0) begin
      hold_len = hold_len - 1;
      out_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        recv_mode = recv_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left  = mode_left - 1;
      ready_tick = ready_tick + 1;
      case (recv_mode)
        RECV_FREE:        out_if.ready <= 1'b1;
        RECV_LIGHT_STALL: out_if.ready <= ($urandom_range(0, 3) != 0);
        RECV_HEAVY_STALL: out_if.ready <= ($urandom_range(0, 3) == 0);
        default:          out_if.ready <= (ready_tick % 5 != 4);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (due_points.size() == 0) begin
        flag_mismatch($sformatf("unexpected point (%0d,%0d)", out_if.point_x,
                                out_if.point_y));
      end else begin
        want = due_points.pop_front();
        if (out_if.point_x !== want.px)
          flag_mismatch($sformatf("point_x %0d want %0d", out_if.point_x, want.px));
        if (out_if.point_y !== want.py)
          flag_mismatch($sformatf("point_y %0d want %0d", out_if.point_y, want.py));
        if (out_if.point_color !== want.col)
          flag_mismatch($sformatf("point_color %h want %h", out_if.point_color, want.col));
        if (out_if.inside_canvas !== want.in_bounds)
          flag_mismatch($sformatf("inside_canvas %b want %b at (%0d,%0d)",
                                  out_if.inside_canvas, want.in_bounds, want.px, want.py));
        if (out_if.last_point !== want.last)
          flag_mismatch($sformatf("last_point %b want %b at (%0d,%0d)",
                                  out_if.last_point, want.last, want.px, want.py));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_CANVAS_W;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.command  = CMD_START;
    in_if.center_x = '0;
    in_if.center_y = '0;
    in_if.radius_x = '0;
    in_if.radius_y = '0;
    in_if.color    = '0;
    lim_width      = 1024;
    lim_height     = 1024;
    ell_active     = 1'b0;
    ell_region_two = 1'b0;
    ctr_x          = 0;
    ctr_y          = 0;
    pos_x          = 0;
    pos_y          = 0;
    slope_x        = 0;
    slope_y        = 0;
    dec_var        = 0;
    rx_sq          = 0;
    ry_sq          = 0;
    ell_color      = '0;
    useful_beats   = 0;
    burst_left     = 0;
    hold_ask       = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_and_zero_radius();
    test_extremes_and_restart();
    test_canvas_bounds();
    test_output_stall();
    test_random_ellipses();
    settle();

    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mpe_pkg.sv
sv/mpe_if.sv
sv/mpe_mul.sv
sv/mpe_point.sv
sv/midpoint_ellipse_outline_top.sv
tb/tb_top.sv
